### sv/sliding_window_average_defines.svh
// Assertion macros shared by the sliding window average RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SLIDING_WINDOW_AVERAGE_DEFINES_SVH
`define SLIDING_WINDOW_AVERAGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWA_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error(msg);

`endif

### sv/swa_pkg.sv
// Package for the sliding window average: field widths, defaults and the
// sequencer state type. No dependencies.
`default_nettype none

package swa_pkg;

	// Fixed field widths.
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned LIMIT_W = 4;

	// Default window storage depth and reset value of the limit register.
	localparam int unsigned       MAX_WINDOW_DEF   = 16;
	localparam logic [LIMIT_W-1:0] WINDOW_LIMIT_RST = 4'd10;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_ADD,
		ST_DIV,
		ST_DONE
	} swa_state_t;

endpackage

`default_nettype wire

### sv/swa_in_if.sv
// Input channel of the sliding window average: one ping time sample per item.
// Depends on swa_pkg for the sample width.
`default_nettype none

interface swa_in_if;
	import swa_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] ping_time;

	modport source (output valid, output ping_time, input ready);
	modport sink (input valid, input ping_time, output ready);
endinterface

`default_nettype wire

### sv/swa_out_if.sv
// Output channel of the sliding window average: mean and held count per item.
// Depends on swa_pkg for the data width; the count width is a parameter.
`default_nettype none

interface swa_out_if #(
	parameter int unsigned CNT_W = 5
);
	import swa_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] average;
	logic [CNT_W-1:0]  entries_held;

	modport source (output valid, output average, output entries_held, input ready);
	modport sink (input valid, input average, input entries_held, output ready);
endinterface

`default_nettype wire

### sv/swa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module swa_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### sv/swa_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// The remainder stays as narrow as the divisor. No package dependencies.
`default_nettype none

module swa_divider #(
	parameter int unsigned SUM_W = 36,
	parameter int unsigned CNT_W = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [SUM_W-1:0] dividend,
	input  wire logic [CNT_W-1:0] divisor,
	output logic                  done,
	output logic      [SUM_W-1:0] quotient
);

	localparam int unsigned BIT_W = $clog2(SUM_W);

	logic [SUM_W-1:0] shift_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] divisor_q;
	logic [BIT_W-1:0] bit_q;
	logic             busy_q;
	logic             done_q;

	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;
	logic             fits;

	// One trial subtraction of the divisor from the partial remainder.
	always_comb begin
		trial = {rem_q, shift_q[SUM_W-1]};
		diff  = trial - {1'b0, divisor_q};
		fits  = (trial >= {1'b0, divisor_q});
	end

	// Payload shift register: dividend bits leave at the top while
	// quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			shift_q   <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			shift_q <= {shift_q[SUM_W-2:0], fits};
			rem_q   <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	// Bit counter and completion strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				bit_q  <= BIT_W'(SUM_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					bit_q <= bit_q - 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = shift_q;

endmodule

`default_nettype wire

### sv/sliding_window_average.sv
// Sliding window average of round-trip time samples. Each accepted item is
// one sample; the block drops the oldest held sample when the held count
// exceeds window_limit or fills the ring, appends the new one and returns
// the truncated mean of the held samples with their count. The mean comes
// from the bit-serial divider, which produces one quotient bit per cycle;
// SUM_W is 36 with the default depth of 16. A new item is taken as soon as
// the previous result has moved into the output register, even while that
// result still waits to be taken.
// Depends on swa_pkg, swa_in_if, swa_out_if, swa_ram, swa_divider and the
// assertion macros in sliding_window_average_defines.svh.
`default_nettype none
`include "sliding_window_average_defines.svh"

module sliding_window_average #(
	parameter int unsigned MAX_WINDOW = swa_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [swa_pkg::LIMIT_W-1:0]  cfg_data,
	swa_in_if.sink                            samples,
	swa_out_if.source                         averages
);
	import swa_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_WINDOW);
	localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int unsigned SUM_W = DATA_W + IDX_W;
	localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	swa_state_t state_q, state_d;

	logic [LIMIT_W-1:0] limit_q;
	logic [IDX_W-1:0]   oldest_q;
	logic [CNT_W-1:0]   count_q;
	logic [SUM_W-1:0]   sum_q;
	logic [DATA_W-1:0]  sample_q;
	logic               drop_q;
	logic               out_valid_q;
	logic [DATA_W-1:0]  out_avg_q;
	logic [CNT_W-1:0]   out_cnt_q;

	logic               accept;
	logic               drop_now;
	logic [CNT_W:0]     slot_sum;
	logic [IDX_W-1:0]   slot;
	logic [IDX_W-1:0]   oldest_inc;
	logic [SUM_W-1:0]   sum_add;
	logic [CNT_W-1:0]   count_inc;
	logic [DATA_W-1:0]  ram_rdata;
	logic               ram_we;
	logic               div_start;
	logic               div_done;
	logic [SUM_W-1:0]   div_quot;
	logic               out_load;

	// Window limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= WINDOW_LIMIT_RST;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	// Drop rule, ring slot arithmetic and the running sum after the append.
	always_comb begin
		accept     = samples.valid && samples.ready;
		drop_now   = (CMP_W'(count_q) > CMP_W'(limit_q)) ||
			(count_q == CNT_W'(MAX_WINDOW));
		slot_sum   = (CNT_W + 1)'(oldest_q) + (CNT_W + 1)'(count_q);
		if (slot_sum >= (CNT_W + 1)'(MAX_WINDOW)) begin
			slot_sum = slot_sum - (CNT_W + 1)'(MAX_WINDOW);
		end
		slot       = slot_sum[IDX_W-1:0];
		oldest_inc = (oldest_q == IDX_W'(MAX_WINDOW - 1)) ? '0 : oldest_q + 1'b1;
		sum_add    = sum_q + SUM_W'(sample_q);
		count_inc  = count_q + 1'b1;
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes.
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SUB;
				end
			end
			ST_SUB: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				ram_we    = 1'b1;
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || averages.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Window bookkeeping: index of the oldest sample, count and sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q  <= '0;
			sum_q    <= '0;
			drop_q   <= 1'b0;
		end else begin
			if (accept) begin
				drop_q <= drop_now;
			end
			if (state_q == ST_SUB && drop_q) begin
				sum_q    <= sum_q - SUM_W'(ram_rdata);
				oldest_q <= oldest_inc;
				count_q  <= count_q - 1'b1;
			end
			if (state_q == ST_ADD) begin
				sum_q   <= sum_add;
				count_q <= count_inc;
			end
		end
	end

	// Captured sample of the item in progress.
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= samples.ping_time;
		end
	end

	// Output register, which frees the input side while a result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (averages.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_avg_q <= div_quot[DATA_W-1:0];
			out_cnt_q <= count_q;
		end
	end

	// Sample ring; the read address is the oldest slot, so the oldest sample
	// is ready in the cycle after an item is accepted.
	swa_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot),
		.wdata (sample_q),
		.raddr (oldest_q),
		.rdata (ram_rdata)
	);

	// Mean of the held samples.
	swa_divider #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_add),
		.divisor  (count_inc),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign samples.ready         = (state_q == ST_IDLE);
	assign averages.valid        = out_valid_q;
	assign averages.average      = out_avg_q;
	assign averages.entries_held = out_cnt_q;

	// Assertions on the sequencer and window bookkeeping.
	`SWA_ASSERT_NEXT(a_accept_to_sub, clk, arst_n, accept, state_q == ST_SUB,
		"accepted item did not start the window update")
	`SWA_ASSERT_IMPL(a_done_in_div, clk, arst_n, div_done, state_q == ST_DIV,
		"divider finished outside the divide state")
	`SWA_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_WINDOW),
		"held count exceeds the ring depth")
	`SWA_ASSERT_IMPL(a_valid_source, clk, arst_n, $rose(out_valid_q),
		$past(state_q) == ST_DONE, "result appeared without a finished division")
	`SWA_ASSERT_IMPL(a_count_nonzero, clk, arst_n, out_valid_q, out_cnt_q != '0,
		"result offered with an empty window")

endmodule

`default_nettype wire
